/* src/bba_pkg.sv */
// ----------------------------------------------------------------------------
// Buddy block allocator package
// Shared defaults, operation, status, node mark and register index codes.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int LEVELS_DEF         = 8;
    localparam int MIN_BLOCK_LOG2_DEF = 6;
    localparam int ALIGN_LOG2_DEF     = 6;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [1:0] ST_RANGE     = 2'd2;
    localparam logic [1:0] ST_NOT_ALLOC = 2'd3;

    localparam logic [1:0] MARK_FREE  = 2'd0;
    localparam logic [1:0] MARK_SPLIT = 2'd1;
    localparam logic [1:0] MARK_ALLOC = 2'd2;

    localparam logic CFG_HEAP_START = 1'b0;
    localparam logic CFG_HEAP_END   = 1'b1;

endpackage

/* src/buddy_block_allocator.sv */
// ----------------------------------------------------------------------------
// Buddy block allocator
// Each request word allocates or frees a power-of-two block and returns one
// result word with status, block address and running totals. A small
// sequencer drives one node mark RAM and two free list link RAMs, each with
// one write port and one registered read port; an allocation steps through
// tree growth and split levels and a free through merge levels, a word
// refused on entry skips them, and a finished result waits for m_axis_tready.
// Free lists and tree state use the link RAMs and a valid bit per node mark;
// an init state after reset seeds the initial free leaf before the first word.
// ----------------------------------------------------------------------------
module buddy_block_allocator
    import bba_pkg::*;
#(
    parameter int LEVELS         = LEVELS_DEF,
    parameter int MIN_BLOCK_LOG2 = MIN_BLOCK_LOG2_DEF,
    parameter int ALIGN_LOG2     = ALIGN_LOG2_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_index,
    input  logic [31:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,   // req_size, req_address
    input  logic         s_axis_tuser,   // operation
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [167:0] m_axis_tdata    // status, block_address, alloc_byte_total,
                                         // alloc_event_total, free_byte_total,
                                         // free_event_total, zero pad
);

    localparam int NODES    = 1 << LEVELS;
    localparam int NW       = LEVELS;
    localparam int PW       = LEVELS + 1;
    localparam int LW       = $clog2(LEVELS);
    localparam int MAX_LOG2 = MIN_BLOCK_LOG2 + LEVELS - 1;
    localparam int SW       = $clog2(MAX_LOG2 + 1);
    localparam logic [31:0] MAX_BLOCK  = 32'd1 << MAX_LOG2;
    localparam logic [32:0] ALIGN_MASK = (33'd1 << ALIGN_LOG2) - 33'd1;
    localparam logic [PW-1:0] NIL      = '1;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_GROW, S_GROW2, S_GLOOP, S_SRCH, S_SPLIT, S_AFIN,
        S_RM0, S_RM1, S_PU0, S_PU1, S_FCHK, S_FLOOP, S_FSIB, S_FMRG, S_FOK, S_DONE
    } t_state;

    function automatic logic [PW-1:0] first_node(input logic [LW-1:0] lv);
        return PW'((1 << lv) - 1);
    endfunction

    function automatic logic ptr_ok(input logic [PW-1:0] p);
        return ~p[PW-1];
    endfunction

    t_state r_state, n_state, r_ret, n_ret;
    logic [31:0]   r_size, n_size;
    logic [LW-1:0] r_lv, n_lv, r_cur, n_cur, r_height, n_height, r_root, n_root;
    logic          r_hneg, n_hneg;
    logic [PW-1:0] r_n, n_n, r_sib, n_sib, r_pn, n_pn, r_ph, n_ph, r_rn, n_rn;
    logic [LW-1:0] r_plv, n_plv, r_rlv, n_rlv;
    logic          r_rpop, n_rpop;
    logic [PW-1:0] r_head [LEVELS];
    logic [PW-1:0] n_head [LEVELS];
    logic [NODES-1:0] r_mval;
    logic          r_mv;
    logic [31:0]   r_start, r_end;
    logic [31:0]   r_asum, n_asum, r_acnt, n_acnt, r_fsum, n_fsum, r_fcnt, n_fcnt;
    logic [1:0]    r_status, n_status;
    logic [31:0]   r_baddr, n_baddr;
    logic          r_ov;
    logic [161:0]  r_odata;

    logic          mark_we;
    logic [NW-1:0] mark_waddr, mark_raddr;
    logic [1:0]    mark_wdata, mark_q, mark_cur;
    logic          nx_we, pv_we;
    logic [NW-1:0] nx_waddr, pv_waddr, lk_raddr;
    logic [PW-1:0] nx_wdata, pv_wdata, nx_q, pv_q;

    logic [32:0]   base;
    logic [31:0]   limit;
    logic [LW-1:0] in_lv;
    logic [31:0]   in_size, in_addr, diff, off_full, off32;
    logic [SW-1:0] sh_in, sh_al;
    logic [PW-1:0] n_free;
    logic          found;
    logic [LW-1:0] found_lv;
    logic [PW-1:0] px, xx, hd, nhd, mn, sibc, hh;
    logic          load_out;

    bba_ram #(.WIDTH(2), .DEPTH(NODES)) u_mark (
        .i_clk(i_clk), .i_we(mark_we), .i_waddr(mark_waddr), .i_wdata(mark_wdata),
        .i_raddr(mark_raddr), .o_rdata(mark_q)
    );
    bba_ram #(.WIDTH(PW), .DEPTH(NODES)) u_next (
        .i_clk(i_clk), .i_we(nx_we), .i_waddr(nx_waddr), .i_wdata(nx_wdata),
        .i_raddr(lk_raddr), .o_rdata(nx_q)
    );
    bba_ram #(.WIDTH(PW), .DEPTH(NODES)) u_prev (
        .i_clk(i_clk), .i_we(pv_we), .i_waddr(pv_waddr), .i_wdata(pv_wdata),
        .i_raddr(lk_raddr), .o_rdata(pv_q)
    );

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {6'd0, r_odata};

    assign in_size  = s_axis_tdata[31:0];
    assign in_addr  = s_axis_tdata[63:32];
    assign base     = ({1'b0, r_start} + ALIGN_MASK) & ~ALIGN_MASK;
    assign limit    = r_end & ~ALIGN_MASK[31:0];
    assign mark_cur = r_mv ? mark_q : MARK_FREE;

    always_comb begin
        in_lv = '0;
        for (int b = 0; b < LEVELS; b++) begin
            if ({1'b0, in_size} <= (33'd1 << (MIN_BLOCK_LOG2 + LEVELS - 1 - b))) begin
                in_lv = LW'(b);
            end
        end
    end

    assign sh_in    = SW'(MAX_LOG2) - SW'(in_lv);
    assign sh_al    = SW'(MAX_LOG2) - SW'(r_lv);
    assign diff     = in_addr - base[31:0];
    assign off_full = diff >> sh_in;
    assign n_free   = first_node(in_lv) + off_full[PW-1:0];
    assign off32    = 32'(r_n - first_node(r_lv)) << sh_al;

    always_comb begin
        found    = 1'b0;
        found_lv = '0;
        for (int i = 0; i < LEVELS; i++) begin
            if (LW'(i) <= r_lv && LW'(i) >= r_root && ptr_ok(r_head[i])) begin
                found    = 1'b1;
                found_lv = LW'(i);
            end
        end
    end

    assign hh   = r_head[r_plv];
    assign hd   = r_head[r_rlv];
    assign px   = pv_q;
    assign xx   = ptr_ok(nx_q) ? nx_q : NIL;
    assign mn   = (r_n < r_sib) ? r_n : r_sib;
    assign sibc = ((r_n - PW'(1)) ^ PW'(1)) + PW'(1);

    always_comb begin
        nhd = hd;
        if (!ptr_ok(px) && hd == r_rn) begin
            nhd = xx;
        end
        if (r_rpop && nhd == r_rn) begin
            nhd = NIL;
        end
    end

    always_comb begin
        n_state = r_state;  n_ret = r_ret;   n_size = r_size;  n_lv = r_lv;
        n_cur = r_cur;      n_height = r_height; n_hneg = r_hneg; n_root = r_root;
        n_n = r_n;          n_sib = r_sib;   n_pn = r_pn;      n_ph = r_ph;
        n_rn = r_rn;        n_plv = r_plv;   n_rlv = r_rlv;    n_rpop = r_rpop;
        n_asum = r_asum;    n_acnt = r_acnt; n_fsum = r_fsum;  n_fcnt = r_fcnt;
        n_status = r_status; n_baddr = r_baddr;
        n_head = r_head;
        mark_we = 1'b0; mark_waddr = r_n[NW-1:0]; mark_wdata = MARK_FREE;
        mark_raddr = r_n[NW-1:0];
        nx_we = 1'b0; nx_waddr = r_pn[NW-1:0]; nx_wdata = NIL;
        pv_we = 1'b0; pv_waddr = r_pn[NW-1:0]; pv_wdata = NIL;
        lk_raddr = r_rn[NW-1:0];
        load_out = 1'b0;
        unique case (r_state)
            S_INIT: begin
                nx_we    = 1'b1;
                nx_waddr = NW'(first_node(LW'(LEVELS - 1)));
                pv_we    = 1'b1;
                pv_waddr = NW'(first_node(LW'(LEVELS - 1)));
                n_state  = S_IDLE;
            end
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_size   = in_size;
                    n_lv     = in_lv;
                    n_height = in_lv;
                    n_hneg   = 1'b0;
                    n_baddr  = '0;
                    if (s_axis_tuser == OP_ALLOC) begin
                        if (in_size > MAX_BLOCK) begin
                            n_status = ST_NO_SPACE;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_GROW;
                        end
                    end else if ({1'b0, in_addr} < base || in_addr >= limit) begin
                        n_status = ST_RANGE;
                        n_state  = S_DONE;
                    end else if (in_size > MAX_BLOCK || (off_full >> in_lv) != '0) begin
                        n_status = ST_NOT_ALLOC;
                        n_state  = S_DONE;
                    end else begin
                        n_n        = n_free;
                        mark_raddr = n_free[NW-1:0];
                        n_state    = S_FCHK;
                    end
                end
            end
            S_GROW: begin
                if (r_hneg) begin
                    n_status = ST_NO_SPACE;
                    n_state  = S_DONE;
                end else if (r_height >= r_root) begin
                    n_state = S_SRCH;
                end else if (ptr_ok(r_head[r_root])) begin
                    n_rn    = r_head[r_root];
                    n_rlv   = r_root;
                    n_rpop  = 1'b1;
                    n_ret   = S_GROW2;
                    n_state = S_RM0;
                end else begin
                    n_state = S_GLOOP;
                end
            end
            S_GROW2: begin
                n_root  = r_height;
                n_plv   = r_height;
                n_pn    = first_node(r_height);
                n_ret   = S_SRCH;
                n_state = S_PU0;
            end
            S_GLOOP: begin
                if (r_height < r_root) begin
                    n_root     = r_root - LW'(1);
                    mark_we    = 1'b1;
                    mark_waddr = NW'(first_node(r_root - LW'(1)));
                    mark_wdata = MARK_SPLIT;
                    n_plv      = r_root;
                    n_pn       = first_node(r_root) + PW'(1);
                    n_ret      = S_GLOOP;
                    n_state    = S_PU0;
                end else begin
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                if (found) begin
                    n_cur   = found_lv;
                    n_n     = r_head[found_lv];
                    n_rn    = r_head[found_lv];
                    n_rlv   = found_lv;
                    n_rpop  = 1'b1;
                    n_ret   = S_SPLIT;
                    n_state = S_RM0;
                end else begin
                    if (r_root == '0) begin
                        n_hneg = 1'b1;
                    end else begin
                        n_height = r_root - LW'(1);
                    end
                    n_state = S_GROW;
                end
            end
            S_SPLIT: begin
                if (r_cur < r_lv) begin
                    mark_we    = 1'b1;
                    mark_wdata = MARK_SPLIT;
                    n_plv      = r_cur + LW'(1);
                    n_pn       = {r_n[PW-2:0], 1'b0} + PW'(2);
                    n_n        = {r_n[PW-2:0], 1'b0} + PW'(1);
                    n_cur      = r_cur + LW'(1);
                    n_ret      = S_SPLIT;
                    n_state    = S_PU0;
                end else begin
                    n_state = S_AFIN;
                end
            end
            S_AFIN: begin
                mark_we    = 1'b1;
                mark_wdata = MARK_ALLOC;
                n_asum     = r_asum + r_size;
                n_acnt     = r_acnt + 32'd1;
                n_baddr    = base[31:0] + off32;
                n_status   = ST_OK;
                n_state    = S_DONE;
            end
            S_RM0: begin
                n_state = S_RM1;
            end
            S_RM1: begin
                if (ptr_ok(px)) begin
                    nx_we    = 1'b1;
                    nx_waddr = px[NW-1:0];
                    nx_wdata = xx;
                end
                if (ptr_ok(xx)) begin
                    pv_we    = 1'b1;
                    pv_waddr = xx[NW-1:0];
                    pv_wdata = ptr_ok(px) ? px : NIL;
                end
                n_head[r_rlv] = nhd;
                n_state       = r_ret;
            end
            S_PU0: begin
                nx_we          = 1'b1;
                nx_wdata       = hh;
                pv_we          = 1'b1;
                n_head[r_plv]  = r_pn;
                n_ph           = hh;
                n_state        = S_PU1;
            end
            S_PU1: begin
                if (ptr_ok(r_ph)) begin
                    pv_we    = 1'b1;
                    pv_waddr = r_ph[NW-1:0];
                    pv_wdata = r_pn;
                end
                n_state = r_ret;
            end
            S_FCHK: begin
                if (mark_cur != MARK_ALLOC) begin
                    n_status = ST_NOT_ALLOC;
                    n_state  = S_DONE;
                end else begin
                    n_fsum  = r_fsum + r_size;
                    n_fcnt  = r_fcnt + 32'd1;
                    n_state = S_FLOOP;
                end
            end
            S_FLOOP: begin
                mark_we    = 1'b1;
                mark_wdata = MARK_FREE;
                if (r_lv <= r_root || r_n == '0) begin
                    n_plv   = r_lv;
                    n_pn    = r_n;
                    n_ret   = S_FOK;
                    n_state = S_PU0;
                end else begin
                    n_sib      = sibc;
                    mark_raddr = sibc[NW-1:0];
                    n_state    = S_FSIB;
                end
            end
            S_FSIB: begin
                if (mark_cur != MARK_FREE) begin
                    n_plv   = r_lv;
                    n_pn    = r_n;
                    n_ret   = S_FOK;
                    n_state = S_PU0;
                end else begin
                    n_rn    = r_sib;
                    n_rlv   = r_lv;
                    n_rpop  = 1'b0;
                    n_ret   = S_FMRG;
                    n_state = S_RM0;
                end
            end
            S_FMRG: begin
                n_n     = (mn - PW'(1)) >> 1;
                n_lv    = r_lv - LW'(1);
                n_state = S_FLOOP;
            end
            S_FOK: begin
                n_status = ST_OK;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (!r_ov || m_axis_tready) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_ret    <= S_IDLE;
            r_root   <= LW'(LEVELS - 1);
            r_asum   <= '0;
            r_acnt   <= '0;
            r_fsum   <= '0;
            r_fcnt   <= '0;
            r_mval   <= '0;
            r_ov     <= 1'b0;
            r_start  <= '0;
            r_end    <= '0;
            for (int i = 0; i < LEVELS; i++) begin
                r_head[i] <= (i == LEVELS - 1) ? first_node(LW'(LEVELS - 1)) : NIL;
            end
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_root  <= n_root;
            r_asum  <= n_asum;
            r_acnt  <= n_acnt;
            r_fsum  <= n_fsum;
            r_fcnt  <= n_fcnt;
            r_head  <= n_head;
            if (mark_we) begin
                r_mval[mark_waddr] <= 1'b1;
            end
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_HEAP_START) begin
                    r_start <= i_cfg_data;
                end else begin
                    r_end <= i_cfg_data;
                end
            end
            if (load_out) begin
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
        r_size   <= n_size;
        r_lv     <= n_lv;
        r_cur    <= n_cur;
        r_height <= n_height;
        r_hneg   <= n_hneg;
        r_n      <= n_n;
        r_sib    <= n_sib;
        r_pn     <= n_pn;
        r_ph     <= n_ph;
        r_rn     <= n_rn;
        r_plv    <= n_plv;
        r_rlv    <= n_rlv;
        r_rpop   <= n_rpop;
        r_status <= n_status;
        r_baddr  <= n_baddr;
        r_mv     <= r_mval[mark_raddr];
        if (load_out) begin
            r_odata <= {r_fcnt, r_fsum, r_acnt, r_asum, r_baddr, r_status};
        end
    end

    a_root_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_root <= LW'(LEVELS - 1))
        else $error("root level out of range");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_ov) |=> r_ov)
        else $error("finished result not presented");

    a_split_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SPLIT) |-> (r_cur <= r_lv))
        else $error("split walked past request level");

endmodule

/* src/bba_ram.sv */
// ----------------------------------------------------------------------------
// Buddy block allocator RAM
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* test/bba_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy block allocator checker
// Watches the register, request and result channels, keeps its own copy of
// the allocator tree and free lists, predicts each result word and compares
// it field by field with what the block returns.
// ----------------------------------------------------------------------------
module bba_checker
    import bba_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    input  logic         i_cfg_ready,
    input  logic         i_cfg_index,
    input  logic [31:0]  i_cfg_data,
    input  logic         i_req_valid,
    input  logic         i_req_ready,
    input  logic [63:0]  i_req_data,
    input  logic         i_req_user,
    input  logic         i_rsp_valid,
    input  logic         i_rsp_ready,
    input  logic [167:0] i_rsp_data,
    output int           o_fail_count,
    output int           o_pending
);

    localparam int          NLEV     = LEVELS_DEF;
    localparam int          NNODE    = 1 << NLEV;
    localparam int          MAXLOG   = MIN_BLOCK_LOG2_DEF + NLEV - 1;
    localparam logic [32:0] MAXBLK   = 33'd1 << MAXLOG;
    localparam logic [32:0] ALGNMASK = (33'd1 << ALIGN_LOG2_DEF) - 33'd1;
    localparam int unsigned NIL      = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [31:0] free_events;
        logic [31:0] free_bytes;
        logic [31:0] alloc_events;
        logic [31:0] alloc_bytes;
        logic [31:0] addr;
        logic [1:0]  status;
    } t_bba_result;

    logic [31:0] cfg_base_raw;
    logic [31:0] cfg_top_raw;
    logic [1:0]  mark [NNODE];
    int unsigned nxt  [NNODE];
    int unsigned prv  [NNODE];
    int unsigned head [NLEV];
    int          root;
    logic [31:0] a_bytes, a_count, f_bytes, f_count;

    t_bba_result expected_words[$];
    int          mismatches;

    assign o_fail_count = mismatches;
    assign o_pending    = expected_words.size();

    function automatic logic [32:0] base_addr();
        return ({1'b0, cfg_base_raw} + ALGNMASK) & ~ALGNMASK;
    endfunction

    function automatic int unsigned first_of(int lv);
        return (1 << lv) - 1;
    endfunction

    function automatic void tree_clear();
        for (int i = 0; i < NNODE; i++) begin
            mark[i] = MARK_FREE;
            nxt[i]  = 0;
            prv[i]  = 0;
        end
        for (int i = 0; i < NLEV; i++) head[i] = NIL;
        root = NLEV - 1;
        nxt[first_of(NLEV - 1)] = NIL;
        prv[first_of(NLEV - 1)] = NIL;
        head[NLEV - 1] = first_of(NLEV - 1);
        a_bytes = 0;
        a_count = 0;
        f_bytes = 0;
        f_count = 0;
    endfunction

    function automatic void push_node(int lv, int unsigned n);
        int unsigned h;
        h = head[lv];
        if (n >= NNODE) return;
        nxt[n] = h;
        prv[n] = NIL;
        if (h < NNODE) prv[h] = n;
        head[lv] = n;
    endfunction

    function automatic void unlink_node(int lv, int unsigned n);
        int unsigned p, x;
        if (n >= NNODE) return;
        p = prv[n];
        x = nxt[n];
        if (x >= NNODE) x = NIL;
        if (p < NNODE) nxt[p] = x;
        else if (head[lv] == n) head[lv] = x;
        if (x < NNODE) prv[x] = (p < NNODE) ? p : NIL;
    endfunction

    function automatic int unsigned pop_node(int lv);
        int unsigned n;
        n = head[lv];
        if (n >= NNODE) return NIL;
        unlink_node(lv, n);
        if (head[lv] == n) head[lv] = NIL;
        return n;
    endfunction

    function automatic int level_of(logic [31:0] size);
        int          b;
        logic [32:0] s;
        b = NLEV - 1;
        s = 33'd1 << MIN_BLOCK_LOG2_DEF;
        while ({1'b0, size} > s && b > 0) begin
            b--;
            s = s << 1;
        end
        return b;
    endfunction

    function automatic bit grow_root(int target);
        int unsigned n;
        if (target < 0) return 1'b0;
        if (target >= root) return 1'b1;
        if (head[root] < NNODE) begin
            void'(pop_node(root));
            root = target;
            push_node(root, first_of(root));
            return 1'b1;
        end
        while (target < root) begin
            root--;
            n = first_of(root);
            mark[n] = MARK_SPLIT;
            push_node(root + 1, 2 * n + 2);
        end
        return 1'b1;
    endfunction

    function automatic void predict_alloc(logic [31:0] size, ref t_bba_result r);
        int          lv, height;
        int unsigned n;
        logic [32:0] off;
        n = NIL;
        if ({1'b0, size} > MAXBLK) begin
            r.status = ST_NO_SPACE;
            return;
        end
        lv = level_of(size);
        height = lv;
        while (n == NIL) begin
            if (!grow_root(height)) begin
                r.status = ST_NO_SPACE;
                return;
            end
            for (int i = lv; i >= root; i--) begin
                if (head[i] < NNODE) begin
                    n = pop_node(i);
                    for (int c = i; c < lv && n < NNODE; c++) begin
                        mark[n] = MARK_SPLIT;
                        push_node(c + 1, 2 * n + 2);
                        n = 2 * n + 1;
                    end
                    break;
                end
            end
            height = root - 1;
        end
        if (n >= NNODE) begin
            r.status = ST_NO_SPACE;
            return;
        end
        a_bytes += size;
        a_count += 1;
        mark[n] = MARK_ALLOC;
        off = 33'(n - first_of(lv)) << (MAXLOG - lv);
        r.status = ST_OK;
        r.addr   = 32'(base_addr() + off);
    endfunction

    function automatic void predict_free(logic [31:0] addr, logic [31:0] size,
                                         ref t_bba_result r);
        logic [32:0] base, off;
        int          lv;
        int unsigned n, sib;
        base = base_addr();
        if ({1'b0, addr} < base || {1'b0, addr} >= ({1'b0, cfg_top_raw} & ~ALGNMASK)) begin
            r.status = ST_RANGE;
            return;
        end
        if ({1'b0, size} > MAXBLK) begin
            r.status = ST_NOT_ALLOC;
            return;
        end
        lv  = level_of(size);
        off = ({1'b0, addr} - base) >> (MAXLOG - lv);
        if (off >= (33'd1 << lv)) begin
            r.status = ST_NOT_ALLOC;
            return;
        end
        n = first_of(lv) + int'(off);
        if (mark[n] != MARK_ALLOC) begin
            r.status = ST_NOT_ALLOC;
            return;
        end
        f_bytes += size;
        f_count += 1;
        forever begin
            mark[n] = MARK_FREE;
            if (lv <= root || n == 0) begin
                push_node(lv, n);
                break;
            end
            sib = ((n - 1) ^ 1) + 1;
            if (sib >= NNODE || mark[sib] != MARK_FREE) begin
                push_node(lv, n);
                break;
            end
            unlink_node(lv, sib);
            n = (((n < sib) ? n : sib) - 1) >> 1;
            lv--;
        end
        r.status = ST_OK;
    endfunction

    function automatic t_bba_result predict_word(logic op, logic [31:0] size,
                                                 logic [31:0] addr);
        t_bba_result r;
        r = '0;
        if (op == OP_ALLOC) predict_alloc(size, r);
        else predict_free(addr, size, r);
        r.alloc_bytes  = a_bytes;
        r.alloc_events = a_count;
        r.free_bytes   = f_bytes;
        r.free_events  = f_count;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_bba_result got, exp_w;
        if (!i_rst_n) begin
            cfg_base_raw = 0;
            cfg_top_raw  = 0;
            tree_clear();
            expected_words.delete();
            mismatches = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_HEAP_START) cfg_base_raw = i_cfg_data;
                else cfg_top_raw = i_cfg_data;
            end
            if (i_req_valid && i_req_ready)
                expected_words.push_back(predict_word(i_req_user, i_req_data[31:0],
                                                      i_req_data[63:32]));
            if (i_rsp_valid && i_rsp_ready) begin
                got = i_rsp_data[161:0];
                if (expected_words.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result word %h", got);
                    mismatches++;
                end else begin
                    exp_w = expected_words.pop_front();
                    if (got.status !== exp_w.status || got.addr !== exp_w.addr ||
                        got.alloc_bytes !== exp_w.alloc_bytes ||
                        got.alloc_events !== exp_w.alloc_events ||
                        got.free_bytes !== exp_w.free_bytes ||
                        got.free_events !== exp_w.free_events) begin
                        if (mismatches < 10)
                            $display("exp %0d %h %h %h %h %h, got %0d %h %h %h %h %h",
                                     exp_w.status, exp_w.addr, exp_w.alloc_bytes,
                                     exp_w.alloc_events, exp_w.free_bytes,
                                     exp_w.free_events, got.status, got.addr,
                                     got.alloc_bytes, got.alloc_events,
                                     got.free_bytes, got.free_events);
                        mismatches++;
                    end
                end
            end
        end
    end

endmodule

/* test/tb_buddy_block_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy block allocator testbench
// Drives directed and random allocate/free words over several heap settings
// with random gaps and back pressure; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_buddy_block_allocator;
    import bba_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct {
        logic        op;
        logic [31:0] size;
        logic [31:0] addr;
    } t_req;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic         i_cfg_index = 1'b0;
    logic [31:0]  i_cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata = '0;   // req_size, req_address
    logic         s_axis_tuser = 1'b0; // operation
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [167:0] m_axis_tdata;        // status, block_address, totals x4, pad

    int   fail_count, pending, idle_cycles, rx_wait;
    bit   no_gaps;
    bit   rsp_taken;
    t_req in_flight[$];
    t_req live_blocks[$];

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    buddy_block_allocator u_top (.*);

    bba_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_req_valid(s_axis_tvalid), .i_req_ready(s_axis_tready),
        .i_req_data(s_axis_tdata), .i_req_user(s_axis_tuser),
        .i_rsp_valid(m_axis_tvalid), .i_rsp_ready(m_axis_tready),
        .i_rsp_data(m_axis_tdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // track granted blocks so frees can target them
    always @(posedge i_clk) begin
        t_req r;
        rsp_taken <= m_axis_tvalid && m_axis_tready;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                in_flight.push_back('{s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32]});
            if (m_axis_tvalid && m_axis_tready && in_flight.size() > 0) begin
                r = in_flight.pop_front();
                if (r.op == OP_ALLOC && m_axis_tdata[1:0] == ST_OK)
                    live_blocks.push_back('{OP_FREE, r.size, m_axis_tdata[33:2]});
            end
        end
    end

    always @(negedge i_clk) begin
        int w;
        if (rsp_taken && !no_gaps) begin
            w = $urandom_range(0, 13);
            rx_wait <= (w > 0) ? w - 1 : 0;
            m_axis_tready <= (w == 0);
        end else if (rx_wait > 0) begin
            rx_wait <= rx_wait - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_cfg_valid && o_cfg_ready) || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || (pending == 0 && !s_axis_tvalid))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic idx, logic [31:0] val);
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        while (pending != 0 || in_flight.size() != 0) @(negedge i_clk);
        repeat (16) @(negedge i_clk);
    endtask

    task automatic set_heap(logic [31:0] start_a, logic [31:0] end_a);
        drain();
        write_reg(CFG_HEAP_START, start_a);
        write_reg(CFG_HEAP_END, end_a);
        i_cfg_valid <= 1'b0;
        live_blocks.delete();
    endtask

    task automatic send_word(logic op, logic [31:0] size, logic [31:0] addr);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tuser  <= op;
        s_axis_tdata  <= {addr, size};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic random_words(int count);
        int          r, k;
        t_req        b;
        logic [31:0] sz;
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 45) begin
                sz = $urandom_range(0, 1 << $urandom_range(6, 13));
                send_word(OP_ALLOC, sz, $urandom);
            end else if (r < 80 && live_blocks.size() > 0) begin
                k = $urandom_range(0, live_blocks.size() - 1);
                b = live_blocks[k];
                if ($urandom_range(0, 9) != 0) live_blocks.delete(k);
                case ($urandom_range(0, 3))
                    0: send_word(OP_FREE, b.size, b.addr | $urandom_range(0, 63));
                    1: send_word(OP_FREE, $urandom_range(0, 8192), b.addr);
                    default: send_word(OP_FREE, b.size, b.addr);
                endcase
            end else if (r < 90) begin
                send_word(OP_FREE, $urandom_range(0, 9000), $urandom_range(0, 32'h0002_0000));
            end else begin
                send_word(1'($urandom_range(0, 1)), $urandom, $urandom);
            end
        end
        s_axis_tvalid <= 1'b0;
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        set_heap(32'h0, 32'h0001_0000);
        no_gaps = 1'b0;
        send_word(OP_ALLOC, 32'd0, 32'hFFFF_FFFF);
        send_word(OP_ALLOC, 32'd8192, 32'h0);
        send_word(OP_ALLOC, 32'd8193, 32'h0);
        send_word(OP_ALLOC, 32'hFFFF_FFFF, 32'h0);
        send_word(OP_FREE, 32'd64, 32'h0002_0000);
        send_word(OP_FREE, 32'd64, 32'hFFFF_FFFF);
        send_word(OP_FREE, 32'd8193, 32'h0);
        send_word(OP_FREE, 32'hFFFF_FFFF, 32'h0);
        send_word(OP_FREE, 32'd64, 32'h0000_0040);
        send_word(OP_FREE, 32'd0, 32'h0000_0003);
        send_word(OP_ALLOC, 32'd1, 32'h0);
        send_word(OP_ALLOC, 32'd100, 32'h0);
        send_word(OP_ALLOC, 32'd8192, 32'h0);
        send_word(OP_ALLOC, 32'd8192, 32'h0);
        send_word(OP_FREE, 32'd8192, 32'h0000_1FFF);
        send_word(OP_FREE, 32'd8192, 32'h0000_8000);
        send_word(OP_FREE, 32'd64, 32'h0000_FFC0);

        random_words(150);
        set_heap(32'h0000_0001, 32'hFFFF_FFFF);
        random_words(150);
        set_heap(32'hFFFF_FFFF, 32'h0);
        random_words(60);
        set_heap(32'h0001_2345, 32'h0001_4000);
        random_words(120);
        set_heap(32'h8000_0000, 32'hFFFF_FFFF);
        random_words(120);

        drain();
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
src/bba_pkg.sv
src/bba_ram.sv
src/buddy_block_allocator.sv
test/bba_checker.sv
test/tb_buddy_block_allocator.sv
